// File: rtl/core/bf3_pkg.sv
// Shared types and constants for the 3x3 box filter.
// No dependencies; bf3_if, bf3_pos and box_filter_3x3_u8 refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

	localparam int PIX_W      = 8;   // pixel and result width
	localparam int LW_W       = 12;  // line_width register
	localparam int LC_W       = 13;  // line_count register
	localparam int ROW_W      = 12;  // row counter
	localparam int SUM_W      = 12;  // sum of nine pixels, up to 2295
	localparam int RECIP_W    = 13;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int MIN_DIM    = 3;
	localparam int MAX_ROWS   = 4096;

	// floor(x/9) == (x*7282)>>16 for all x in 0..2295
	localparam logic [RECIP_W-1:0] RECIP_NINE_Q16 = 13'd7282;

	localparam logic [LW_W-1:0] LW_RESET = 12'd640;
	localparam logic [LC_W-1:0] LC_RESET = 13'd480;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 1'd1;

	// per-pixel position flags from the counter block
	typedef struct packed {
		logic emit;  // window is complete, a result follows
		logic eol;
		logic eof;
	} pos_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/bf3_if.sv
// Stream channel interfaces (valid/ready) for pixels in and filtered words out.
// Depends on bf3_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface bf3_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bf3_pkg::PIX_W-1:0]  pixel;
	logic                       start_of_frame;

	modport source (output valid, output pixel, output start_of_frame, input ready);
	modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface bf3_box_if;
	logic                       valid;
	logic                       ready;
	logic [bf3_pkg::PIX_W-1:0]  box_value;
	logic                       end_of_line;
	logic                       end_of_frame;

	modport source (output valid, output box_value, output end_of_line,
		output end_of_frame, input ready);
	modport sink   (input valid, input box_value, input end_of_line,
		input end_of_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bf3_line_mem.sv
// Line store: simple dual-port RAM, one write and one registered read per cycle.
// Standalone; used by box_filter_3x3_u8.
`timescale 1ns / 1ps
`default_nettype none

module bf3_line_mem #(
	parameter int DEPTH = 2048,
	parameter int DW    = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the old word on a same-cycle collision; caller forwards
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bf3_pos.sv
// Configuration registers and column/row position counters.
// Depends on bf3_pkg; instantiated by box_filter_3x3_u8.
`timescale 1ns / 1ps
`default_nettype none

module bf3_pos #(
	parameter int MAX_LINE = 2048,
	parameter int CW       = $clog2(MAX_LINE)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             accept,
	input  wire logic                             sof,
	output logic      [CW-1:0]                    col,
	output bf3_pkg::pos_flags_t                   flags
);

	localparam int CMP_W = (CW + 1 > bf3_pkg::LW_W) ? CW + 1 : bf3_pkg::LW_W;

	logic [bf3_pkg::LW_W-1:0]  lw_q;
	logic [bf3_pkg::LC_W-1:0]  lc_q;
	logic [CW-1:0]             col_q;
	logic [bf3_pkg::ROW_W-1:0] row_q;
	logic [bf3_pkg::ROW_W-1:0] row;
	logic [CMP_W-1:0]          lw_x;
	logic [CW-1:0]             last_col;
	logic [bf3_pkg::ROW_W-1:0] last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= bf3_pkg::LW_RESET;
			lc_q <= bf3_pkg::LC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bf3_pkg::REG_LINE_WIDTH: lw_q <= cfg_data[bf3_pkg::LW_W-1:0];
				bf3_pkg::REG_LINE_COUNT: lc_q <= cfg_data;
			endcase
		end
	end

	// clamp width to 3..MAX_LINE and count to 3..4096, as last index
	always_comb begin
		lw_x = CMP_W'(lw_q);
		if (lw_x < CMP_W'(bf3_pkg::MIN_DIM)) begin
			last_col = CW'(bf3_pkg::MIN_DIM - 1);
		end else if (lw_x > CMP_W'(MAX_LINE)) begin
			last_col = CW'(MAX_LINE - 1);
		end else begin
			last_col = CW'(lw_x - CMP_W'(1));
		end

		if (lc_q < bf3_pkg::LC_W'(bf3_pkg::MIN_DIM)) begin
			last_row = bf3_pkg::ROW_W'(bf3_pkg::MIN_DIM - 1);
		end else if (lc_q > bf3_pkg::LC_W'(bf3_pkg::MAX_ROWS)) begin
			last_row = bf3_pkg::ROW_W'(bf3_pkg::MAX_ROWS - 1);
		end else begin
			last_row = bf3_pkg::ROW_W'(lc_q - bf3_pkg::LC_W'(1));
		end
	end

	always_comb begin
		col        = sof ? '0 : col_q;
		row        = sof ? '0 : row_q;
		flags.eol  = col >= last_col;
		flags.eof  = flags.eol && (row >= last_row);
		flags.emit = (row >= bf3_pkg::ROW_W'(2)) && (col >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (flags.eol) begin
				col_q <= '0;
				row_q <= flags.eof ? '0 : row + bf3_pkg::ROW_W'(1);
			end else begin
				col_q <= col + CW'(1);
				row_q <= row;
			end
		end
	end

	a_eol_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.eol |=> col_q == '0)
		else $error("column did not wrap at end of line");

	a_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !flags.eol |=> col_q == $past(col) + CW'(1))
		else $error("column did not advance by one");

	a_eof_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.eof |=> row_q == '0 && col_q == '0)
		else $error("position did not return to origin at end of frame");

endmodule

`default_nettype wire

// File: rtl/core/box_filter_3x3_u8.sv
// 3x3 box filter (floor mean of nine pixels) for an 8-bit raster stream.
// Depends on bf3_pkg, bf3_if, bf3_line_mem and bf3_pos.
//
// Usage:
//   pix   : input words, one pixel each in raster order, border included.
//           start_of_frame on a word restarts the position at row 0, column 0.
//   box   : output words, one per pixel at row >= 2 and column >= 2, holding
//           the floor mean of the window centered one row up and one column
//           left, with end-of-line / end-of-frame marks.
//   cfg_* : write line_width (index 0) and line_count (index 1) while idle.
// Throughput: one pixel per clock. The line store is a single RAM holding
//   both previous lines per column, read and written back once per pixel.
// Pipeline: a result passes the stage 1 register (the RAM read runs
//   alongside it), the window update, the sum register and the multiply
//   into the output register.
// Stall: while an output word waits, pixels that make no result still flow;
//   the pipeline holds only when a second result would overtake it.
// Reset: counters, window and valid flags clear at once; the line store is not
//   cleared, its first two lines of each frame are never used for output.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_u8 #(
	parameter int MAX_LINE = 2048
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bf3_pix_if.sink                               pix,
	bf3_box_if.source                             box,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_LINE);
	localparam int PW = bf3_pkg::PIX_W;
	localparam int DW = 2 * PW;

	logic                 enable;
	logic                 accept;
	logic [AW-1:0]        col;
	bf3_pkg::pos_flags_t  flags;
	logic                 fwd;

	// stage 1: line store data
	logic                 vld_s1;
	logic                 fwd_s1;
	logic [AW-1:0]        addr_s1;
	logic [PW-1:0]        px_s1;
	bf3_pkg::pos_flags_t  flags_s1;
	logic [DW-1:0]        rd_data;
	logic [DW-1:0]        wr_word_q;
	logic [DW-1:0]        col_word;
	logic [DW-1:0]        wr_word;
	logic                 wr_en;

	// stage 2: window complete
	logic                 res_s2;
	logic                 eol_s2;
	logic                 eof_s2;
	logic [8:0][PW-1:0]   win_q;
	logic [bf3_pkg::SUM_W-1:0] win_sum;
	logic [bf3_pkg::SUM_W-1:0] cs0, cs1, cs2;

	// stage 3: sum ready
	logic                 res_s3;
	logic                 eol_s3;
	logic                 eof_s3;
	logic [bf3_pkg::SUM_W-1:0] sum_s3;
	logic [bf3_pkg::PROD_W-1:0] prod;

	logic                 out_vld_q;
	logic [PW-1:0]        out_val_q;
	logic                 out_eol_q;
	logic                 out_eof_q;

	// hold only if a waiting word would be overwritten by a new result
	assign enable    = !out_vld_q || box.ready || !res_s3;
	assign pix.ready = enable;
	assign accept    = pix.valid && enable;

	bf3_pos #(.MAX_LINE(MAX_LINE), .CW(AW)) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.sof       (pix.start_of_frame),
		.col       (col),
		.flags     (flags)
	);

	// same column written by stage 1 this cycle: RAM read is stale
	assign fwd = vld_s1 && (addr_s1 == col);

	bf3_line_mem #(.DEPTH(MAX_LINE), .DW(DW), .AW(AW)) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (enable) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1   <= fwd;
			addr_s1  <= col;
			px_s1    <= pix.pixel;
			flags_s1 <= flags;
		end
	end

	// word layout: [DW-1:PW] two lines up, [PW-1:0] one line up
	assign col_word = fwd_s1 ? wr_word_q : rd_data;
	assign wr_word  = {col_word[PW-1:0], px_s1};
	assign wr_en    = enable && vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_word_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]     <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
			end
			win_q[2] <= col_word[DW-1:PW];
			win_q[5] <= col_word[PW-1:0];
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
			res_s3 <= 1'b0;
		end else if (enable) begin
			res_s2 <= vld_s1 && flags_s1.emit;
			res_s3 <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			eol_s2 <= flags_s1.eol;
			eof_s2 <= flags_s1.eof;
			eol_s3 <= eol_s2;
			eof_s3 <= eof_s2;
			sum_s3 <= win_sum;
		end
	end

	always_comb begin
		cs0 = bf3_pkg::SUM_W'(win_q[0]) + bf3_pkg::SUM_W'(win_q[3])
			+ bf3_pkg::SUM_W'(win_q[6]);
		cs1 = bf3_pkg::SUM_W'(win_q[1]) + bf3_pkg::SUM_W'(win_q[4])
			+ bf3_pkg::SUM_W'(win_q[7]);
		cs2 = bf3_pkg::SUM_W'(win_q[2]) + bf3_pkg::SUM_W'(win_q[5])
			+ bf3_pkg::SUM_W'(win_q[8]);
		win_sum = cs0 + cs1 + cs2;
	end

	assign prod = bf3_pkg::PROD_W'(sum_s3) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_NINE_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || box.ready) begin
			out_vld_q <= res_s3 && enable;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || box.ready) begin
			out_val_q <= prod[16 +: PW];
			out_eol_q <= eol_s3;
			out_eof_q <= eof_s3;
		end
	end

	assign box.valid        = out_vld_q;
	assign box.box_value    = out_val_q;
	assign box.end_of_line  = out_eol_q;
	assign box.end_of_frame = out_eof_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !box.ready && res_s3 |-> !pix.ready)
		else $error("result would overwrite a waiting output word");

	a_emit_col: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && flags_s1.emit |-> addr_s1 >= AW'(2))
		else $error("result flagged before the window is complete");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !enable |=> vld_s1 && $stable(addr_s1) && $stable(px_s1))
		else $error("stage 1 word changed during a hold");

	a_eof_eol: assert property (@(posedge clk) disable iff (!arst_n)
		res_s3 && eof_s3 |-> eol_s3)
		else $error("end of frame without end of line");

endmodule

`default_nettype wire
